### hdl/aih_pkg.sv
// Shared types, constants and hash arithmetic for the assembly identity hash.
`default_nettype none

package aih_pkg;

   // Match progress codes for the "none" and "version" recognizers.
   localparam logic [2:0] NONE_LEN  = 3'd4;
   localparam logic [2:0] NONE_FAIL = 3'd5;
   localparam logic [3:0] VER_LEN   = 4'd7;
   localparam logic [3:0] VER_FAIL  = 4'd8;

   typedef logic [3:0][31:0] lane_array_type;

   // One input item as held in the input register.
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last_byte;
      logic       last_pair;
   } req_item_type;

   // End of one string: final lane sums and what the string matched.
   typedef struct packed {
      logic           kind;
      logic           last_pair;
      logic           is_none;
      logic           is_version;
      lane_array_type lanes;
   } str_end_type;

   // End of one string after the lanes are mixed into 64 bits.
   typedef struct packed {
      logic        kind;
      logic        last_pair;
      logic        is_none;
      logic        is_version;
      logic [63:0] hash;
   } mixed_end_type;

   // Character of "none" at a given match position.
   function automatic logic [7:0] none_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h6E;
         2'd1:    c = 8'h6F;
         2'd2:    c = 8'h6E;
         default: c = 8'h65;
      endcase
      return c;
   endfunction

   // Character of "version" at a given match position.
   function automatic logic [7:0] version_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h76;
         3'd1:    c = 8'h65;
         3'd2:    c = 8'h72;
         3'd3:    c = 8'h73;
         3'd4:    c = 8'h69;
         3'd5:    c = 8'h6F;
         3'd6:    c = 8'h6E;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // lane * 0x1003F + byte, with 0x1003F = 2^16 + 2^6 - 1.
   function automatic logic [31:0] lane_step(input logic [31:0] x, input logic [7:0] b);
      return (x << 16) + (x << 6) - x + {24'd0, b};
   endfunction

   // x * 0x1FFFFFFF7 mod 2^64, with 0x1FFFFFFF7 = 2^33 - 9.
   function automatic logic [63:0] mul_c(input logic [63:0] x);
      return (x << 33) - (x << 3) - x;
   endfunction

   // Mix the four lanes into 64 bits. The wide multipliers split into small ones:
   // 0x1E5FFFFFD27 = 0x1E6 * 2^32 - 0x2D9 and
   // 0xFFFFFFDC00000051 = -(0x24 * 2^32) + 0x51 (mod 2^64).
   function automatic logic [63:0] mix_lanes(input lane_array_type l);
      logic [40:0] a0h;
      logic [41:0] a0l;
      logic [37:0] a1h;
      logic [38:0] a1l;
      logic [63:0] x2;
      logic [63:0] x3;
      a0h = 41'(l[0]) * 41'h1E6;
      a0l = 42'(l[0]) * 42'h2D9;
      a1h = 38'(l[1]) * 38'h24;
      a1l = 39'(l[1]) * 39'h51;
      x2  = {32'd0, l[2]};
      x3  = {32'd0, l[3]};
      return {a0h[31:0], 32'd0} - 64'(a0l) - {a1h[31:0], 32'd0} + 64'(a1l)
             + mul_c(x2) + x3;
   endfunction

endpackage

`default_nettype wire

### hdl/aih_string.sv
// Per-string lane hashing and word matching, one byte per cycle while the pipeline advances.
`default_nettype none

module aih_string (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 item_valid,
   input  wire aih_pkg::req_item_type item,
   output logic                      ev_valid,
   output aih_pkg::str_end_type      ev
);

   aih_pkg::lane_array_type lane_ff, lane_in, snap;
   logic [1:0]              pos_ff, pos_in;
   logic [2:0]              none_ff, none_in, none_nxt;
   logic [3:0]              ver_ff, ver_in, ver_nxt;
   logic                    ev_valid_ff, ev_valid_in;
   aih_pkg::str_end_type    ev_ff, ev_in;
   logic                    take;
   logic                    ends;

   // Apply the byte to its lane and advance both matchers.
   always_comb begin
      take = item_valid && item.byte_valid;
      ends = item_valid && item.last_byte;
      snap = lane_ff;
      none_nxt = none_ff;
      ver_nxt = ver_ff;
      if (take) begin
         snap[pos_ff] = aih_pkg::lane_step(lane_ff[pos_ff], item.data_byte);
         if (none_ff < aih_pkg::NONE_LEN &&
             item.data_byte == aih_pkg::none_char(none_ff[1:0])) begin
            none_nxt = none_ff + 3'd1;
         end else begin
            none_nxt = aih_pkg::NONE_FAIL;
         end
         if (ver_ff < aih_pkg::VER_LEN &&
             item.data_byte == aih_pkg::version_char(ver_ff[2:0])) begin
            ver_nxt = ver_ff + 4'd1;
         end else begin
            ver_nxt = aih_pkg::VER_FAIL;
         end
      end
   end

   // The string state clears at the end of a string; otherwise it keeps the update.
   always_comb begin
      if (ends) begin
         lane_in = '0;
         pos_in  = 2'd0;
         none_in = 3'd0;
         ver_in  = 4'd0;
      end else begin
         lane_in = snap;
         pos_in  = take ? pos_ff + 2'd1 : pos_ff;
         none_in = none_nxt;
         ver_in  = ver_nxt;
      end
      ev_valid_in      = ends;
      ev_in.kind       = item.kind;
      ev_in.last_pair  = item.last_pair;
      ev_in.is_none    = (none_nxt == aih_pkg::NONE_LEN);
      ev_in.is_version = (ver_nxt == aih_pkg::VER_LEN);
      ev_in.lanes      = snap;
   end

   // String state and the end-of-string register.
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff     <= '0;
         pos_ff      <= 2'd0;
         none_ff     <= 3'd0;
         ver_ff      <= 4'd0;
         ev_valid_ff <= 1'b0;
      end else if (adv) begin
         lane_ff     <= lane_in;
         pos_ff      <= pos_in;
         none_ff     <= none_in;
         ver_ff      <= ver_in;
         ev_valid_ff <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ev_ff <= ev_in;
      end
   end

   assign ev_valid = ev_valid_ff;
   assign ev       = ev_ff;

endmodule

`default_nettype wire

### hdl/aih_fold.sv
// Lane mixing, pair folding into the two accumulators, and the result register.
`default_nettype none

module aih_fold (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                ev_valid,
   input  wire aih_pkg::str_end_type ev,
   input  wire logic                rsp_ready,
   output logic                     hold,
   output logic                     rsp_valid,
   output logic [63:0]              rsp_full_hash,
   output logic [63:0]              rsp_no_version_hash
);

   logic                  c_valid_ff;
   aih_pkg::mixed_end_type c_ff, c_in;
   logic [63:0]           attr_c_ff, attr_c_in;
   logic                  attr_ver_ff, attr_ver_in;
   logic [63:0]           full_ff, full_in;
   logic [63:0]           part_ff, part_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [63:0]           full_hash_ff, part_hash_ff;
   logic [63:0]           both;
   logic [63:0]           full_fold, part_fold;
   logic                  is_value;
   logic                  emit;

   // Mix stage: the four lane sums become the 64-bit string hash.
   always_comb begin
      c_in.kind       = ev.kind;
      c_in.last_pair  = ev.last_pair;
      c_in.is_none    = ev.is_none;
      c_in.is_version = ev.is_version;
      c_in.hash       = aih_pkg::mix_lanes(ev.lanes);
   end

   // Fold stage: an attribute is stored, a value other than "none" folds its pair into the accumulators.
   always_comb begin
      is_value    = c_valid_ff && c_ff.kind;
      emit        = is_value && c_ff.last_pair;
      both        = c_ff.hash + attr_c_ff;
      full_fold   = both + aih_pkg::mul_c(full_ff);
      part_fold   = both + aih_pkg::mul_c(part_ff);
      attr_c_in   = attr_c_ff;
      attr_ver_in = attr_ver_ff;
      full_in     = full_ff;
      part_in     = part_ff;
      if (c_valid_ff && !c_ff.kind) begin
         attr_c_in   = aih_pkg::mul_c(c_ff.hash);
         attr_ver_in = c_ff.is_version;
      end
      if (is_value && !c_ff.is_none) begin
         full_in = full_fold;
         if (!attr_ver_ff) begin
            part_in = part_fold;
         end
      end
   end

   // The pipeline stops only when a result is due and the last one is still waiting.
   always_comb begin
      hold         = emit && rsp_valid_ff && !rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (adv && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control and accumulator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         attr_c_ff    <= 64'd0;
         attr_ver_ff  <= 1'b0;
         full_ff      <= 64'd0;
         part_ff      <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            c_valid_ff  <= ev_valid;
            attr_c_ff   <= attr_c_in;
            attr_ver_ff <= attr_ver_in;
            full_ff     <= emit ? 64'd0 : full_in;
            part_ff     <= emit ? 64'd0 : part_in;
         end
      end
   end

   // Payload registers for the mixed hash and the result item.
   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff <= c_in;
         if (emit) begin
            full_hash_ff <= full_in;
            part_hash_ff <= part_in;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_full_hash       = full_hash_ff;
   assign rsp_no_version_hash = part_hash_ff;

endmodule

`default_nettype wire

### hdl/assembly_identity_hash.sv
// Top level of the assembly identity hash: input register and the two hashing stages.
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_ready  kind, data_byte, byte_valid, last_byte,
//                                              last_pair
//   rsp_      out         rsp_valid/rsp_ready  full_hash, no_version_hash
//
// One item is accepted every cycle that req_ready is high. A result becomes valid once the
// item ending the last value string has passed the input register, lane update, lane mix
// and pair fold registers.
// Reset clears all lanes, matchers, the stored attribute and both accumulators.
// The pipeline stalls only while a new result is due and the previous result has not
// been taken; req_ready is low in exactly those cycles.
`default_nettype none

module assembly_identity_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_last_byte,
   input  wire logic        req_last_pair,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_full_hash,
   output logic [63:0]      rsp_no_version_hash
);

   logic                  adv;
   logic                  hold;
   logic                  in_valid_ff;
   aih_pkg::req_item_type in_ff, in_in;
   logic                  ev_valid;
   aih_pkg::str_end_type  ev;

   // Every stage moves together unless the result register is blocked.
   assign adv       = !hold;
   assign req_ready = adv;

   always_comb begin
      in_in.kind       = req_kind;
      in_in.data_byte  = req_data_byte;
      in_in.byte_valid = req_byte_valid;
      in_in.last_byte  = req_last_byte;
      in_in.last_pair  = req_last_pair;
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= in_in;
      end
   end

   aih_string u_string (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .item_valid (in_valid_ff),
      .item       (in_ff),
      .ev_valid   (ev_valid),
      .ev         (ev)
   );

   aih_fold u_fold (
      .clock               (clock),
      .reset               (reset),
      .adv                 (adv),
      .ev_valid            (ev_valid),
      .ev                  (ev),
      .rsp_ready           (rsp_ready),
      .hold                (hold),
      .rsp_valid           (rsp_valid),
      .rsp_full_hash       (rsp_full_hash),
      .rsp_no_version_hash (rsp_no_version_hash)
   );

endmodule

`default_nettype wire
